// File: rtl/smob_pkg.sv
// Shared constants, register indexes, class codes and the config struct
// for the screen/multiply opacity blend. No dependencies.
`timescale 1ns / 1ps

package smob_pkg;

	localparam int CHAN_W        = 16;
	localparam int FRAC_BITS_DEF = 15;
	localparam int FIFO_DEPTH    = 4;   // power of two
	localparam int CFG_ADDR_W    = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_COMP_MODE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_OPACITY   = 2'd1;

	localparam logic [1:0] MODE_NONE     = 2'd0;
	localparam logic [1:0] MODE_SCREEN   = 2'd1;
	localparam logic [1:0] MODE_MULTIPLY = 2'd2;

	// what the back end does with a word
	localparam logic [1:0] CLS_LAYER    = 2'd0;
	localparam logic [1:0] CLS_SOURCE   = 2'd1;
	localparam logic [1:0] CLS_SCREEN   = 2'd2;
	localparam logic [1:0] CLS_MULTIPLY = 2'd3;

	typedef struct packed {
		logic [1:0]        comp_mode;
		logic [CHAN_W-1:0] opacity;
	} cfg_t;

endpackage

// File: rtl/smob_if.sv
// Valid/ready channel interfaces: pixel input, pixel output, config write.
// Depends on smob_pkg.
`timescale 1ns / 1ps

interface smob_in_if import smob_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] src_red;
	logic [CHAN_W-1:0] src_green;
	logic [CHAN_W-1:0] src_blue;
	logic [CHAN_W-1:0] src_alpha;
	logic [CHAN_W-1:0] layer_red;
	logic [CHAN_W-1:0] layer_green;
	logic [CHAN_W-1:0] layer_blue;
	logic [CHAN_W-1:0] layer_alpha;

	modport source (output valid, src_red, src_green, src_blue, src_alpha,
		layer_red, layer_green, layer_blue, layer_alpha, input ready);
	modport sink (input valid, src_red, src_green, src_blue, src_alpha,
		layer_red, layer_green, layer_blue, layer_alpha, output ready);
endinterface

interface smob_out_if import smob_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] out_red;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_blue;
	logic [CHAN_W-1:0] out_alpha;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface smob_cfg_if import smob_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CHAN_W-1:0]     data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// File: rtl/screen_multiply_opacity_blend.sv
// Top level of the screen/multiply blend with opacity mix: config registers,
// front end, queue, back end. Depends on smob_pkg, smob_if, smob_front,
// smob_fifo, smob_back.
`timescale 1ns / 1ps

// Usage
//   pix_in  : valid/ready word with a straight-alpha source pixel and layer pixel,
//             16 bits a channel, one at 1 << CHANNEL_FRACTION_BITS. Values above
//             one are clamped on entry.
//   pix_out : valid/ready word with the blended straight-alpha RGBA result.
//   cfg     : valid/ready write port, addr 0 = blend mode (none/screen/multiply),
//             addr 1 = opacity. Always ready. Write only while the block is empty.
// Throughput: one word per clock, sustained, with a ready sink.
// Pipeline: from the input accept edge to output valid, the first of 4 front
//   stages loads at the accept edge, then come one queue slot, two pipelined
//   dividers of CHANNEL_FRACTION_BITS + 2 stages each, 3 mix stages and the
//   output register. The dividers produce one quotient bit per stage.
// Back pressure: when the sink stalls, the back end freezes in place; the front
//   keeps accepting until its 4-entry queue fills, then drops ready.
// Reset (arst_n low): all valids cleared, queue emptied, blend mode = none,
//   opacity = one.

module screen_multiply_opacity_blend import smob_pkg::*; #(
	parameter int CHANNEL_FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	smob_in_if.sink        pix_in,
	smob_out_if.source     pix_out,
	smob_cfg_if.sink       cfg
);
	localparam int CW = CHANNEL_FRACTION_BITS + 1;
	localparam int IW = (CW > CHAN_W) ? CW : CHAN_W;
	localparam int EW = 2 + 9 * CW + 3 * (CW + 1);
	localparam logic [CW-1:0] ONE = {1'b1, {CHANNEL_FRACTION_BITS{1'b0}}};

	// config registers
	logic [1:0]        comp_mode_q;
	logic [CHAN_W-1:0] opacity_q;
	cfg_t              cfg_cur;

	// front/back link
	logic              in_ready;
	logic              fifo_push, fifo_pop, fifo_full, fifo_empty;
	logic [EW-1:0]     fifo_wdata, fifo_rdata;
	logic [7:0][CHAN_W-1:0] in_word;
	logic [3:0][CHAN_W-1:0] out_word;
	logic              out_valid;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_mode_q <= MODE_NONE;
			opacity_q   <= CHAN_W'(IW'(ONE));
		end else if (cfg.valid) begin
			priority if (cfg.addr == REG_COMP_MODE) begin
				comp_mode_q <= cfg.data[1:0];
			end else if (cfg.addr == REG_OPACITY) begin
				opacity_q <= cfg.data;
			end else begin
				// unmapped index, ignored
				comp_mode_q <= comp_mode_q;
			end
		end
	end

	assign cfg_cur.comp_mode = comp_mode_q;
	assign cfg_cur.opacity   = opacity_q;

	// word lanes 0..3: source r,g,b,a; 4..7: layer r,g,b,a
	assign in_word = {pix_in.layer_alpha, pix_in.layer_blue, pix_in.layer_green,
		pix_in.layer_red, pix_in.src_alpha, pix_in.src_blue, pix_in.src_green,
		pix_in.src_red};
	assign pix_in.ready = in_ready;

	smob_front #(
		.CHANNEL_FRACTION_BITS (CHANNEL_FRACTION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_cur),
		.in_valid  (pix_in.valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.push      (fifo_push),
		.push_data (fifo_wdata),
		.full      (fifo_full)
	);

	smob_fifo #(
		.W     (EW),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.wdata  (fifo_wdata),
		.full   (fifo_full),
		.pop    (fifo_pop),
		.rdata  (fifo_rdata),
		.empty  (fifo_empty)
	);

	smob_back #(
		.CHANNEL_FRACTION_BITS (CHANNEL_FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_cur),
		.empty     (fifo_empty),
		.pop_data  (fifo_rdata),
		.pop       (fifo_pop),
		.out_valid (out_valid),
		.out_ready (pix_out.ready),
		.out_word  (out_word)
	);

	assign pix_out.valid     = out_valid;
	assign pix_out.out_red   = out_word[0];
	assign pix_out.out_green = out_word[1];
	assign pix_out.out_blue  = out_word[2];
	assign pix_out.out_alpha = out_word[3];

`ifndef SYNTHESIS
	// a stalled output must freeze the back end, so nothing leaves the queue
	a_stall_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && !pix_out.ready) |-> !fifo_pop)
		else $error("queue popped while output stalled");

	// queue count consistency
	a_fifo_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_full && fifo_empty))
		else $error("queue full and empty at once");

	// mixed or blended alpha never exceeds one
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid |-> (IW'(pix_out.out_alpha) <= IW'(ONE)))
		else $error("output alpha above one");

	// front only drops ready because the queue is full with a word waiting
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> fifo_full)
		else $error("input stalled with room in the queue");
`endif

endmodule

// File: rtl/smob_fifo.sv
// Small register queue between the front and back ends.
// No dependencies; it uses nothing from smob_pkg.
`timescale 1ns / 1ps

module smob_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;

	assign full  = (cnt_q == NW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + NW'(1);
				2'b01:   cnt_q <= cnt_q - NW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/smob_div.sv
// Pipelined restoring divider, one quotient bit per stage, several numerators
// over one shared divisor, with a sideband carried alongside. No package use.
`timescale 1ns / 1ps

module smob_div #(
	parameter int LANES = 3,
	parameter int NW    = 33,
	parameter int DW    = 16,
	parameter int QW    = 16,
	parameter int SBW   = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [LANES-1:0][NW-1:0]     num,
	input  logic [DW-1:0]                den,
	input  logic [SBW-1:0]               sb_in,
	output logic                         out_valid,
	output logic [LANES-1:0][QW-1:0]     quo,
	output logic [SBW-1:0]               sb_out
);
	localparam int TW = NW - QW;

	logic                          v    [0:QW];
	logic [LANES-1:0][DW-1:0]      rem  [0:QW];
	logic [LANES-1:0][QW-1:0]      lo   [0:QW];
	logic [LANES-1:0][QW-1:0]      q    [0:QW];
	logic [LANES-1:0]              ovf  [0:QW];
	logic [DW-1:0]                 d    [0:QW];
	logic [SBW-1:0]                sb   [0:QW];

	logic [LANES-1:0][TW-1:0] top;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			top[l] = num[l][NW-1:QW];
		end
	end

	// stage 0: overflow check (quotient would not fit) and initial remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (en) begin
			v[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				ovf[0][l] <= (top[l] >= TW'(den));
				rem[0][l] <= DW'(top[l]);
				lo[0][l]  <= num[l][QW-1:0];
				q[0][l]   <= '0;
			end
			d[0]  <= den;
			sb[0] <= sb_in;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [LANES-1:0][DW:0] r2;
		logic [LANES-1:0]       ge;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				r2[l] = {rem[i][l], lo[i][l][QW-1]};
				ge[l] = (r2[l] >= {1'b0, d[i]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[i+1] <= 1'b0;
			end else if (en) begin
				v[i+1] <= v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					rem[i+1][l] <= ge[l] ? DW'(r2[l] - {1'b0, d[i]}) : DW'(r2[l]);
					lo[i+1][l]  <= lo[i][l] << 1;
					q[i+1][l]   <= {q[i][l][QW-2:0], ge[l]};
				end
				ovf[i+1] <= ovf[i];
				d[i+1]   <= d[i];
				sb[i+1]  <= sb[i];
			end
		end
	end

	assign out_valid = v[QW];
	assign sb_out    = sb[QW];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quo[l] = ovf[QW][l] ? '1 : q[QW][l];
		end
	end

endmodule

// File: rtl/smob_front.sv
// Front end: input saturation, classification and the blend products up to
// the pre-division numerator. Depends on smob_pkg.
`timescale 1ns / 1ps

module smob_front import smob_pkg::*; #(
	parameter int CHANNEL_FRACTION_BITS = FRAC_BITS_DEF,
	localparam int CW = CHANNEL_FRACTION_BITS + 1,
	localparam int EW = 2 + 9 * CW + 3 * (CW + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0][CHAN_W-1:0]  in_word,
	output logic                    push,
	output logic [EW-1:0]           push_data,
	input  logic                    full
);
	localparam int F  = CHANNEL_FRACTION_BITS;
	localparam int IW = (CW > CHAN_W) ? CW : CHAN_W;
	localparam int PW = 2 * CW;
	localparam logic [CW-1:0] ONE  = {1'b1, {F{1'b0}}};
	localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

	function automatic logic [CW-1:0] sat_in(input logic [CHAN_W-1:0] v);
		logic [IW-1:0] t;
		t = IW'(v);
		return (t > IW'(ONE)) ? ONE : CW'(t);
	endfunction

	function automatic logic [CW-1:0] fmul(input logic [CW-1:0] x, input logic [CW-1:0] y);
		logic [PW-1:0] p;
		p = PW'(x) * PW'(y) + HALF;
		return CW'(p >> F);
	endfunction

	function automatic logic [CW-1:0] sat1(input logic [CW:0] x);
		return (x > {1'b0, ONE}) ? ONE : CW'(x);
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [3:0][CW-1:0] s_in, l_in;
	logic [1:0]         cls_in;

	logic [3:0][CW-1:0] s_s1, l_s1, s_s2, l_s2, s_s3, l_s3, s_s4, l_s4;
	logic [1:0]         cls_s1, cls_s2, cls_s3, cls_s4;
	logic [2:0][CW-1:0] ip_s2, op_s2;
	logic [CW-1:0]      pa_s2;
	logic [2:0][CW-1:0] x_s3, y_s3;
	logic [2:0][CW:0]   sum_s3, sum_s4;
	logic [CW-1:0]      a_s3, a_s4;
	logic [2:0][CW-1:0] pr_s4;

	logic [2:0][CW-1:0] x_nx, y_nx;
	logic [2:0][CW:0]   sum_nx;
	logic [CW-1:0]      a_nx;
	logic [2:0][CW:0]   n_out;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			s_in[k] = sat_in(in_word[k]);
			l_in[k] = sat_in(in_word[4+k]);
		end
		if (cfg.comp_mode == MODE_SCREEN || cfg.comp_mode == MODE_MULTIPLY) begin
			priority if (s_in[3] == '0) begin
				cls_in = CLS_LAYER;
			end else if (l_in[3] == '0) begin
				cls_in = CLS_SOURCE;
			end else begin
				cls_in = (cfg.comp_mode == MODE_SCREEN) ? CLS_SCREEN : CLS_MULTIPLY;
			end
		end else begin
			cls_in = CLS_LAYER;
		end
	end

	assign en       = !(v_s4 && full);
	assign in_ready = en;
	assign push     = v_s4 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// union alpha and the multiply-mode matte weights
	always_comb begin
		a_nx = sat1({1'b0, s_s2[3]} + {1'b0, l_s2[3]} - {1'b0, pa_s2});
		for (int k = 0; k < 3; k++) begin
			sum_nx[k] = {1'b0, ip_s2[k]} + {1'b0, op_s2[k]};
			if (cls_s2 == CLS_MULTIPLY) begin
				x_nx[k] = sat1({1'b0, ip_s2[k]} + {1'b0, ONE} - {1'b0, s_s2[3]});
				y_nx[k] = sat1({1'b0, op_s2[k]} + {1'b0, ONE} - {1'b0, l_s2[3]});
			end else begin
				x_nx[k] = ip_s2[k];
				y_nx[k] = op_s2[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1   <= s_in;
			l_s1   <= l_in;
			cls_s1 <= cls_in;

			for (int k = 0; k < 3; k++) begin
				ip_s2[k] <= fmul(s_s1[k], s_s1[3]);
				op_s2[k] <= fmul(l_s1[k], l_s1[3]);
			end
			pa_s2  <= fmul(s_s1[3], l_s1[3]);
			s_s2   <= s_s1;
			l_s2   <= l_s1;
			cls_s2 <= cls_s1;

			x_s3   <= x_nx;
			y_s3   <= y_nx;
			sum_s3 <= sum_nx;
			a_s3   <= a_nx;
			s_s3   <= s_s2;
			l_s3   <= l_s2;
			cls_s3 <= cls_s2;

			for (int k = 0; k < 3; k++) begin
				pr_s4[k] <= fmul(x_s3[k], y_s3[k]);
			end
			sum_s4 <= sum_s3;
			a_s4   <= a_s3;
			s_s4   <= s_s3;
			l_s4   <= l_s3;
			cls_s4 <= cls_s3;
		end
	end

	// division numerator, clamped at zero
	always_comb begin
		logic [CW+1:0] t;
		for (int k = 0; k < 3; k++) begin
			if (cls_s4 == CLS_MULTIPLY) begin
				t = {2'b0, pr_s4[k]} + {2'b0, a_s4} - {2'b0, ONE};
			end else begin
				t = {1'b0, sum_s4[k]} - {2'b0, pr_s4[k]};
			end
			n_out[k] = t[CW+1] ? '0 : t[CW:0];
		end
	end

	assign push_data = {cls_s4, s_s4, l_s4, a_s4, n_out};

endmodule

// File: rtl/smob_back.sv
// Back end: blend division, opacity mix, mix division and output register.
// Depends on smob_pkg and smob_div.
`timescale 1ns / 1ps

module smob_back import smob_pkg::*; #(
	parameter int CHANNEL_FRACTION_BITS = FRAC_BITS_DEF,
	localparam int CW = CHANNEL_FRACTION_BITS + 1,
	localparam int EW = 2 + 9 * CW + 3 * (CW + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    empty,
	input  logic [EW-1:0]           pop_data,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [3:0][CHAN_W-1:0]  out_word
);
	localparam int F    = CHANNEL_FRACTION_BITS;
	localparam int IW   = (CW > CHAN_W) ? CW : CHAN_W;
	localparam int PW   = 2 * CW;
	localparam int NW   = 2 * CW + 1;
	localparam int SB1W = 2 + 9 * CW;
	localparam int SB2W = 9 * CW;
	localparam logic [CW-1:0] ONE  = {1'b1, {F{1'b0}}};
	localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

	function automatic logic [CW-1:0] fmul(input logic [CW-1:0] x, input logic [CW-1:0] y);
		logic [PW-1:0] p;
		p = PW'(x) * PW'(y) + HALF;
		return CW'(p >> F);
	endfunction

	logic en;
	logic out_valid_q;
	logic [3:0][CHAN_W-1:0] out_word_q;

	// queue word
	logic [1:0]         f_cls;
	logic [3:0][CW-1:0] f_s, f_l;
	logic [CW-1:0]      f_a;
	logic [2:0][CW:0]   f_n;

	logic [CW-1:0]           den1;
	logic [2:0][NW-1:0]      num1;
	logic                    d1_valid;
	logic [2:0][CW-1:0]      q1;
	logic [SB1W-1:0]         sb1_o;
	logic [1:0]              d1_cls;
	logic [3:0][CW-1:0]      d1_s, d1_l;
	logic [CW-1:0]           d1_a;
	logic [3:0][CW-1:0]      b_nx;

	logic                    v_s1, v_s2, v_s3;
	logic [3:0][CW-1:0]      b_s1, s_s1, b_s2, s_s2, b_s3, s_s3;
	logic [2:0][CW-1:0]      bp_s2, ip_s2;
	logic [PW-1:0]           pb_s2, ps_s2;
	logic [CW-1:0]           a_s3;
	logic [2:0][PW-1:0]      num_s3;
	logic [PW-1:0]           am;
	logic [CW-1:0]           op_c, r2;

	logic [2:0][NW-1:0]      num2;
	logic                    d2_valid;
	logic [2:0][CW-1:0]      q2;
	logic [SB2W-1:0]         sb2_o;
	logic [CW-1:0]           d2_a;
	logic [3:0][CW-1:0]      d2_b, d2_s;
	logic [3:0][CW-1:0]      r_nx;
	logic [IW-1:0]           op_iw;

	assign {f_cls, f_s, f_l, f_a, f_n} = pop_data;

	assign en        = !out_valid_q || out_ready;
	assign pop       = en && !empty;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// blend division by the union alpha; pass-through words divide by one
	always_comb begin
		den1 = (f_cls == CLS_SCREEN || f_cls == CLS_MULTIPLY) ? f_a : ONE;
		for (int k = 0; k < 3; k++) begin
			num1[k] = (NW'(f_n[k]) << F) + NW'(den1 >> 1);
		end
	end

	smob_div #(
		.LANES (3),
		.NW    (NW),
		.DW    (CW),
		.QW    (CW),
		.SBW   (SB1W)
	) u_div_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pop),
		.num       (num1),
		.den       (den1),
		.sb_in     ({f_cls, f_s, f_l, f_a}),
		.out_valid (d1_valid),
		.quo       (q1),
		.sb_out    (sb1_o)
	);

	assign {d1_cls, d1_s, d1_l, d1_a} = sb1_o;

	always_comb begin
		unique case (d1_cls)
			CLS_SCREEN, CLS_MULTIPLY: begin
				for (int k = 0; k < 3; k++) begin
					b_nx[k] = (q1[k] > ONE) ? ONE : q1[k];
				end
				b_nx[3] = d1_a;
			end
			CLS_LAYER:  b_nx = d1_l;
			CLS_SOURCE: b_nx = d1_s;
		endcase
	end

	assign op_c = CW'(cfg.opacity);
	assign r2   = ONE - op_c;
	assign am   = (pb_s2 + ps_s2 + HALF) >> F;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= d1_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1 <= b_nx;
			s_s1 <= d1_s;

			for (int k = 0; k < 3; k++) begin
				bp_s2[k] <= fmul(b_s1[k], b_s1[3]);
				ip_s2[k] <= fmul(s_s1[k], s_s1[3]);
			end
			pb_s2 <= PW'(b_s1[3]) * PW'(op_c);
			ps_s2 <= PW'(s_s1[3]) * PW'(r2);
			b_s2  <= b_s1;
			s_s2  <= s_s1;

			a_s3 <= (am > PW'(ONE)) ? ONE : CW'(am);
			for (int k = 0; k < 3; k++) begin
				num_s3[k] <= PW'(bp_s2[k]) * PW'(op_c) + PW'(ip_s2[k]) * PW'(r2);
			end
			b_s3 <= b_s2;
			s_s3 <= s_s2;

			if (d2_valid) begin
				for (int k = 0; k < 4; k++) begin
					out_word_q[k] <= CHAN_W'(IW'(r_nx[k]));
				end
			end
		end
	end

	// mix division by the mixed alpha
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num2[k] = NW'(num_s3[k]) + NW'(a_s3 >> 1);
		end
	end

	smob_div #(
		.LANES (3),
		.NW    (NW),
		.DW    (CW),
		.QW    (CW),
		.SBW   (SB2W)
	) u_div_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (num2),
		.den       (a_s3),
		.sb_in     ({a_s3, b_s3, s_s3}),
		.out_valid (d2_valid),
		.quo       (q2),
		.sb_out    (sb2_o)
	);

	assign {d2_a, d2_b, d2_s} = sb2_o;
	assign op_iw = IW'(cfg.opacity);

	always_comb begin
		priority if (op_iw == '0) begin
			r_nx = d2_s;
		end else if (op_iw >= IW'(ONE)) begin
			r_nx = d2_b;
		end else begin
			r_nx[3] = d2_a;
			for (int k = 0; k < 3; k++) begin
				if (d2_a == '0) begin
					r_nx[k] = '0;
				end else begin
					r_nx[k] = (q2[k] > ONE) ? ONE : q2[k];
				end
			end
		end
	end

endmodule
